FILE: rtl/core/first_match_ip_access_list_macros.svh
// Assertion helpers for the access list core.
// Both sample on clk and are switched off while rst is high.
`ifndef FIRST_MATCH_IP_ACCESS_LIST_MACROS_SVH
`define FIRST_MATCH_IP_ACCESS_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FMACL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("access list check failed");

// The consequent must hold in the cycle after the antecedent.
`define FMACL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("access list check failed");

`endif

FILE: rtl/core/fmacl_pkg.sv
package fmacl_pkg;

  localparam int RULES = 64;
  localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int CNT_W = $clog2(RULES + 1);

  localparam int MODE_W      = 2;
  localparam int ADDR_HALF_W = 64;
  localparam int PREFIX_W    = 8;
  localparam int HIT_INDEX_W = 6;
  localparam int STATUS_W    = 2;

  localparam int V4_BITS = 32;
  localparam int V6_BITS = 128;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_PREFIX = 2'd2
  } status_t;

  typedef struct packed {
    logic [ADDR_HALF_W-1:0] addr_high;
    logic [ADDR_HALF_W-1:0] addr_low;
    logic [PREFIX_W-1:0]    prefix;
    logic                   family;
    logic                   permits;
  } rule_t;

  typedef struct packed {
    logic                   allowed;
    logic                   hit;
    logic [HIT_INDEX_W-1:0] hit_index;
    logic [STATUS_W-1:0]    status;
  } result_t;

endpackage

FILE: rtl/core/fmacl_intf.sv
interface fmacl_req_if;
  import fmacl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [MODE_W-1:0]      mode;
  logic                   family;
  logic [ADDR_HALF_W-1:0] address_high;
  logic [ADDR_HALF_W-1:0] address_low;
  logic [PREFIX_W-1:0]    prefix_len;
  logic                   rule_permits;

  modport source (
    output valid, mode, family, address_high, address_low, prefix_len, rule_permits,
    input  ready
  );

  modport sink (
    input  valid, mode, family, address_high, address_low, prefix_len, rule_permits,
    output ready
  );
endinterface

interface fmacl_rsp_if;
  import fmacl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   allowed;
  logic                   hit;
  logic [HIT_INDEX_W-1:0] hit_index;
  logic [STATUS_W-1:0]    status;

  modport source (
    output valid, allowed, hit, hit_index, status,
    input  ready
  );

  modport sink (
    input  valid, allowed, hit, hit_index, status,
    output ready
  );
endinterface

FILE: rtl/core/first_match_ip_access_list.sv
// Clear, append and unused-mode transactions go from acceptance to ST_DONE, then to the output register.
// A query reads one rule per cycle from the rule memory, stopping at the first match or after
// the last rule; an empty table skips the scan and goes straight to ST_DONE.
// One transaction is in flight at a time; the next is taken the cycle after its result moves
// to the output register, which may still wait on the sink meanwhile.
// Synchronous reset empties the table and the output register; rule storage keeps its contents.
`include "first_match_ip_access_list_macros.svh"

module first_match_ip_access_list (
  input logic          clk,
  input logic          rst,
  fmacl_req_if.sink    request,
  fmacl_rsp_if.source  response
);
  import fmacl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  rule_t mem [RULES];
  rule_t rd_rule;
  rule_t new_rule;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] rule_count;
  logic [IDX_W-1:0] chk_idx;
  logic             q_family;
  logic [2*ADDR_HALF_W-1:0] q_addr;

  result_t res;
  result_t first_res;
  result_t out_data;
  logic    out_valid;

  logic accept;
  logic slot_free;
  logic table_full;
  logic wide_prefix;
  logic do_write;
  logic last_rule;
  logic rule_match;
  logic [2*ADDR_HALF_W-1:0] mask;
  logic [2*ADDR_HALF_W-1:0] mask_v6;
  logic [V4_BITS-1:0]       mask_v4;

  assign request.ready = (state == ST_IDLE);
  assign accept        = request.valid && request.ready;
  assign slot_free     = !out_valid || response.ready;

  assign table_full  = rule_count >= CNT_W'(RULES);
  assign wide_prefix = request.family ? (request.prefix_len > PREFIX_W'(V6_BITS))
                                      : (request.prefix_len > PREFIX_W'(V4_BITS));
  assign do_write    = accept && (request.mode == MODE_APPEND) && !table_full && !wide_prefix;

  // IPv4 rules are stored with the unused upper bits cleared.
  always_comb begin
    new_rule.addr_high = request.family ? request.address_high : '0;
    new_rule.addr_low  = request.family ? request.address_low
                                        : {{(ADDR_HALF_W-V4_BITS){1'b0}},
                                           request.address_low[V4_BITS-1:0]};
    new_rule.prefix    = request.prefix_len;
    new_rule.family    = request.family;
    new_rule.permits   = request.rule_permits;
  end

  // Result of a transaction that needs no scan, or the starting point of a query.
  always_comb begin
    first_res = '0;
    case (request.mode)
      MODE_APPEND: begin
        if (table_full) begin
          first_res.status = STATUS_FULL;
        end else if (wide_prefix) begin
          first_res.status = STATUS_PREFIX;
        end
      end
      MODE_QUERY: begin
        if (rule_count == '0) begin
          first_res.allowed = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // While scanning, fetch the rule after the one being checked.
  assign rd_addr = (state == ST_SCAN) ? chk_idx + 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[rule_count[IDX_W-1:0]] <= new_rule;
    end
    rd_rule <= mem[rd_addr];
  end

  // A shift by the full width gives an all-zero mask, which covers a zero prefix.
  assign mask_v6 = {(2*ADDR_HALF_W){1'b1}} << (PREFIX_W'(V6_BITS) - rd_rule.prefix);
  assign mask_v4 = {V4_BITS{1'b1}} << (6'(V4_BITS) - rd_rule.prefix[5:0]);
  assign mask    = rd_rule.family ? mask_v6 : {{(2*ADDR_HALF_W-V4_BITS){1'b0}}, mask_v4};

  assign rule_match = (rd_rule.family == q_family) &&
                      (((q_addr ^ {rd_rule.addr_high, rd_rule.addr_low}) & mask) == '0);
  assign last_rule  = (CNT_W'(chk_idx) + 1'b1) == rule_count;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((request.mode == MODE_QUERY) && (rule_count != '0)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (rule_match || last_rule) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rule_count <= '0;
      chk_idx    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_DONE) && slot_free) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            q_family <= request.family;
            q_addr   <= {request.address_high, request.address_low};
            chk_idx  <= '0;
            res      <= first_res;
            case (request.mode)
              MODE_CLEAR: begin
                rule_count <= '0;
              end
              MODE_APPEND: begin
                if (!table_full && !wide_prefix) begin
                  rule_count <= rule_count + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (rule_match) begin
            res <= '{allowed: rd_rule.permits, hit: 1'b1,
                     hit_index: HIT_INDEX_W'(chk_idx), status: STATUS_OK};
          end else begin
            chk_idx <= chk_idx + 1'b1;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            out_data <= res;
          end
        end
        default: ;
      endcase
    end
  end

  assign response.valid     = out_valid;
  assign response.allowed   = out_data.allowed;
  assign response.hit       = out_data.hit;
  assign response.hit_index = out_data.hit_index;
  assign response.status    = out_data.status;

  `FMACL_ASSERT_IMPL(a_count_bound, 1'b1, rule_count <= CNT_W'(RULES))
  `FMACL_ASSERT_IMPL(a_scan_in_table, state == ST_SCAN, CNT_W'(chk_idx) < rule_count)
  `FMACL_ASSERT_NEXT(a_append_grows, do_write, rule_count == $past(rule_count) + 1'b1)
  `FMACL_ASSERT_NEXT(a_done_releases, state == ST_DONE && slot_free, out_valid && state == ST_IDLE)

endmodule
